@@ rtl/mav_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mav_pkg
// Shared constants, register codes and control types of the moving average.
// ----------------------------------------------------------------------------
package mav_pkg;

  localparam int WSIZE_W        = 7;   // window_size register width
  localparam int GAIN_W         = 21;  // scale_gain register width, Q5.16
  localparam int GAIN_FRAC_BITS = 16;
  localparam int MV_W           = 16;  // voltage output width
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = GAIN_W;
  localparam int FS_W           = 12;

  localparam logic [FS_W-1:0]    FULL_SCALE_MV = 12'd3300;
  localparam logic [WSIZE_W-1:0] WSIZE_RESET   = 7'd16;
  localparam logic [GAIN_W-1:0]  GAIN_RESET    = 21'd65536;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_GAIN  = 1'b1;

  // control from the sequencer to the sample ring
  typedef struct packed {
    logic clr;    // drop history
    logic rd_en;  // fetch the entry at the write pointer
    logic upd;    // replace that entry, update sum and fill
  } ring_ctrl_t;

endpackage

@@ rtl/mav_ring.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mav_ring
// Sample history memory with write pointer, fill count and running sum.
// ----------------------------------------------------------------------------
module mav_ring #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 12,
  parameter int PTR_W       = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
  parameter int CNT_W       = $clog2(WINDOW_MAX + 1),
  parameter int SUM_W       = SAMPLE_BITS + CNT_W
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mav_pkg::ring_ctrl_t     ctrl_i,
  input  logic [CNT_W-1:0]        win_i,
  input  logic [SAMPLE_BITS-1:0]  sample_i,
  output logic [SUM_W-1:0]        sum_o,
  output logic [CNT_W-1:0]        fill_o,
  output logic                    full_o
);
  import mav_pkg::*;

  logic [SAMPLE_BITS-1:0] mem_q [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0] rd_q;
  logic [PTR_W-1:0]       wp_q, wp_d;
  logic [CNT_W-1:0]       fill_q, fill_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic                   full_now;

  // one read, one write port; an item reads then writes the same slot
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rd_q <= mem_q[wp_q];
    end
    if (ctrl_i.upd) begin
      mem_q[wp_q] <= sample_i;
    end
  end

  assign full_now = (fill_q == win_i);

  always_comb begin
    wp_d   = wp_q;
    fill_d = fill_q;
    sum_d  = sum_q;
    if (ctrl_i.clr) begin
      wp_d   = '0;
      fill_d = '0;
      sum_d  = '0;
    end else if (ctrl_i.upd) begin
      if (full_now) begin
        // oldest code sits in this slot
        sum_d = sum_q - SUM_W'(rd_q) + SUM_W'(sample_i);
      end else begin
        fill_d = fill_q + CNT_W'(1);
        sum_d  = sum_q + SUM_W'(sample_i);
      end
      if ((CNT_W'(wp_q) + CNT_W'(1)) == win_i) begin
        wp_d = '0;
      end else begin
        wp_d = wp_q + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
      sum_q  <= '0;
    end else begin
      wp_q   <= wp_d;
      fill_q <= fill_d;
      sum_q  <= sum_d;
    end
  end

  assign sum_o  = sum_q;
  assign fill_o = fill_q;
  assign full_o = full_now;

endmodule

@@ rtl/mav_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mav_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mav_div #(
  parameter int DIVIDEND_W = 24,
  parameter int DIVISOR_W  = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  busy_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);
  import mav_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  dvs_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  busy_q;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign fits    = (shifted >= {1'b0, dvs_q});

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(DIVIDEND_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

@@ rtl/adc_moving_average_voltage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_moving_average_voltage
// Boxcar average of converter codes with a gain-compensated millivolt value.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  s_axis   | in        | tvalid / tready         | tdata: sample
//  m_axis   | out       | tvalid / tready         | tdata: average_code, voltage_mv
//           |           |                         | tuser: window_full
//  cfg      | in        | cfg_we_i (no wait)      | cfg_idx_i, cfg_wdata_i
//
// One item at a time: ring read, ring update, two multiply stages, then the
// bit-serial divide by the fill count.
// The result register lets the next item enter while a result waits.
// Reset initialises pointer, fill count, sum, state, output valid and config;
// ring contents are left as they are and only used after being written.
// ----------------------------------------------------------------------------
module adc_moving_average_voltage #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // sample
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // average_code, voltage_mv
  output logic [((SAMPLE_BITS+16+7)/8)*8-1:0]    m_axis_tdata,
  // window_full
  output logic                                   m_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  input  logic                                   cfg_we_i,
  input  logic [mav_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [mav_pkg::CFG_DATA_W-1:0]         cfg_wdata_i
);
  import mav_pkg::*;

  localparam int CNT_W    = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W    = SAMPLE_BITS + CNT_W;
  localparam int P1_W     = SUM_W + FS_W;
  localparam int P2_W     = P1_W + GAIN_W;
  localparam int DIV_W    = P2_W - SAMPLE_BITS - GAIN_FRAC_BITS;
  localparam int OUT_W    = ((SAMPLE_BITS + MV_W + 7) / 8) * 8;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_UPD  = 3'd1;
  localparam logic [2:0] ST_MUL1 = 3'd2;
  localparam logic [2:0] ST_MUL2 = 3'd3;
  localparam logic [2:0] ST_DIVS = 3'd4;
  localparam logic [2:0] ST_DIVW = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0]             state_q, state_d;
  logic [WSIZE_W-1:0]     wsize_q;
  logic [GAIN_W-1:0]      gain_q;
  logic [CNT_W-1:0]       win;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [P1_W-1:0]        p1_q;
  logic [P2_W-1:0]        p2_q;
  ring_ctrl_t             ring_ctrl;
  logic [SUM_W-1:0]       sum;
  logic [CNT_W-1:0]       fill;
  logic                   full;
  logic                   div_start;
  logic                   avg_busy, mv_busy;
  logic [DIV_W-1:0]       avg_quo, mv_quo;
  logic                   s_acc;
  logic                   out_free;
  logic                   out_load;
  logic                   out_valid_q;
  logic [SAMPLE_BITS-1:0] avg_q;
  logic [MV_W-1:0]        mv_q;
  logic                   full_q;
  logic [MV_W-1:0]        mv_sat;

  // effective window: zero counts as one, large values clamp
  always_comb begin
    if (wsize_q == '0) begin
      win = CNT_W'(1);
    end else if (32'(wsize_q) > WINDOW_MAX) begin
      win = CNT_W'(WINDOW_MAX);
    end else begin
      win = CNT_W'(wsize_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsize_q <= WSIZE_RESET;
      gain_q  <= GAIN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WINDOW_SIZE: wsize_q <= cfg_wdata_i[WSIZE_W-1:0];
        REG_SCALE_GAIN:  gain_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign ring_ctrl.clr   = cfg_we_i && (cfg_idx_i == REG_WINDOW_SIZE);
  assign ring_ctrl.rd_en = s_acc;
  assign ring_ctrl.upd   = (state_q == ST_UPD);
  assign div_start       = (state_q == ST_DIVS);

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: if (s_acc) state_d = ST_UPD;
      ST_UPD:  state_d = ST_MUL1;
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_DIVS;
      ST_DIVS: state_d = ST_DIVW;
      ST_DIVW: if (!avg_busy && !mv_busy) state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      sample_q <= s_axis_tdata[SAMPLE_BITS-1:0];
    end
    if (state_q == ST_MUL1) begin
      p1_q <= P1_W'(sum) * P1_W'(FULL_SCALE_MV);
    end
    if (state_q == ST_MUL2) begin
      p2_q <= P2_W'(p1_q) * P2_W'(gain_q);
    end
    if (out_load) begin
      avg_q  <= avg_quo[SAMPLE_BITS-1:0];
      mv_q   <= mv_sat;
      full_q <= full;
    end
  end

  assign mv_sat = (|mv_quo[DIV_W-1:MV_W]) ? {MV_W{1'b1}} : mv_quo[MV_W-1:0];

  mav_ring #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ring_ctrl),
    .win_i    (win),
    .sample_i (sample_q),
    .sum_o    (sum),
    .fill_o   (fill),
    .full_o   (full)
  );

  mav_div #(
    .DIVIDEND_W (DIV_W),
    .DIVISOR_W  (CNT_W)
  ) u_div_avg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (DIV_W'(sum)),
    .divisor_i  (fill),
    .busy_o     (avg_busy),
    .quotient_o (avg_quo)
  );

  // floor(floor(p2 / 2^k) / fill) equals floor(p2 / (fill * 2^k))
  mav_div #(
    .DIVIDEND_W (DIV_W),
    .DIVISOR_W  (CNT_W)
  ) u_div_mv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (p2_q[P2_W-1:SAMPLE_BITS+GAIN_FRAC_BITS]),
    .divisor_i  (fill),
    .busy_o     (mv_busy),
    .quotient_o (mv_quo)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({mv_q, avg_q});
  assign m_axis_tuser  = full_q;

  // no new item while the dividers are running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |-> (!avg_busy && !mv_busy))
    else $error("item accepted during divide");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill <= win)
    else $error("fill count above window");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && (cfg_idx_i == REG_WINDOW_SIZE)) |=> (fill == '0 && sum == '0))
    else $error("window write did not clear history");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |-> (fill != '0 || win != '0))
    else $error("ring update with no window");

endmodule
